>>> rtl/core/ilid_pkg.sv
// Shared types, codes and elaboration helpers for the positional list store.
`default_nettype none
package ilid_pkg;

	// request actions
	localparam logic [2:0] ACT_READ       = 3'd0;
	localparam logic [2:0] ACT_INS_HEAD   = 3'd1;
	localparam logic [2:0] ACT_INS_TAIL   = 3'd2;
	localparam logic [2:0] ACT_INS_BEFORE = 3'd3;
	localparam logic [2:0] ACT_DELETE     = 3'd4;

	// result status
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_BADPOS = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	localparam logic [31:0] RD_INVALID = 32'hFFFF_FFFF;

	// fan-in of one read tree node
	localparam int RADIX_LOG = 3;
	localparam int RADIX     = 1 << RADIX_LOG;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL
	} cell_op_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t    op;
		logic [31:0] data;
	} cell_cmd_t;

	typedef struct packed {
		logic [8:0]  entry_count;
		logic [1:0]  status;
		logic [31:0] read_value;
	} res_t;

	// node count of a tree level (level 0 = leaves)
	function automatic int node_cnt(int leaves, int lvl);
		int n;
		n = leaves;
		for (int k = 0; k < lvl; k++)
			n = (n + RADIX - 1) >> RADIX_LOG;
		return n;
	endfunction

	// registered levels needed to reach a single root
	function automatic int tree_levels(int leaves);
		int n;
		int l;
		n = leaves;
		l = 0;
		while (n > 1) begin
			n = (n + RADIX - 1) >> RADIX_LOG;
			l++;
		end
		if (l < 1)
			l = 1;
		return l;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/ilid_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbours.
`default_nettype none
module ilid_cell #(
	parameter int IW  = 8,
	parameter int IDX = 0
) (
	input  wire logic                clk,
	input  wire ilid_pkg::cell_cmd_t cmd,
	input  wire logic [IW-1:0]       sel,
	input  wire logic [IW-1:0]       rd_sel,
	input  wire logic [31:0]         left,
	input  wire logic [31:0]         right,
	output logic      [31:0]         entry,
	output logic      [31:0]         hit
);
	import ilid_pkg::*;

	logic [31:0] entry_q;
	logic        at_sel;
	logic        past_sel;

	assign at_sel   = (sel == IW'(IDX));
	assign past_sel = (IW'(IDX) > sel);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (past_sel)
					entry_q <= left;
				else if (at_sel)
					entry_q <= cmd.data;
			end
			CELL_DEL: begin
				if (past_sel || at_sel)
					entry_q <= right;
			end
			default: ;
		endcase
	end

	assign entry = entry_q;
	// only the addressed cell drives the read tree
	assign hit   = (rd_sel == IW'(IDX)) ? entry_q : '0;

endmodule
`default_nettype wire

>>> rtl/core/ilid_or_tree.sv
// Registered OR tree that gathers the single addressed cell's word.
`default_nettype none
module ilid_or_tree #(
	parameter int LEAVES = 256
) (
	input  wire logic        clk,
	input  wire logic [31:0] leaf [LEAVES],
	output logic      [31:0] root
);
	import ilid_pkg::*;

	localparam int LVLS = tree_levels(LEAVES);

	logic [31:0] lvl_q [1:LVLS][LEAVES];

	for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
		localparam int NPREV = node_cnt(LEAVES, l - 1);
		localparam int NCUR  = node_cnt(LEAVES, l);
		for (genvar n = 0; n < LEAVES; n++) begin : g_node
			if (n < NCUR) begin : g_live
				logic [31:0] acc;
				if (l == 1) begin : g_first
					always_comb begin
						acc = '0;
						for (int j = 0; j < RADIX; j++) begin
							if (n * RADIX + j < NPREV)
								acc = acc | leaf[(n * RADIX + j < NPREV) ? n * RADIX + j : 0];
						end
					end
				end else begin : g_upper
					always_comb begin
						acc = '0;
						for (int j = 0; j < RADIX; j++) begin
							if (n * RADIX + j < NPREV)
								acc = acc | lvl_q[l-1][(n * RADIX + j < NPREV) ?
									n * RADIX + j : 0];
						end
					end
				end
				always_ff @(posedge clk) begin
					lvl_q[l][n] <= acc;
				end
			end else begin : g_dead
				always_ff @(posedge clk) begin
					lvl_q[l][n] <= '0;
				end
			end
		end
	end

	assign root = lvl_q[LVLS][0];

endmodule
`default_nettype wire

>>> rtl/core/indexed_list_insert_delete_unit.sv
// Top level of the positional list store: request decode, cell chain and read tree.
//
//  channel | dir | tdata fields (lsb first)                           | width
//  --------+-----+----------------------------------------------------+------
//  s_*     | in  | action[2:0] position[18:3] value[50:19], zero pad | 56
//  m_*     | out | read_value[31:0] status[33:32] entry_count[42:34] | 48
//
// Cycles: insert and delete shift the whole chain of cells in the cycle the
// request is taken, so such requests can follow one per cycle while the
// output register drains. A valid read is gathered through the registered
// OR tree, and no new request is taken until its result is loaded into the output register.
// Reset clears the count and control only; entry words are not cleared, as
// nothing beyond the count is ever read. s_tready is high only while no
// request is in flight; a held result waits in the output register and the
// next request is still taken behind it.
`default_nettype none
module indexed_list_insert_delete_unit #(
	parameter int CAPACITY = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // action[2:0], position[18:3], value[50:19]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata   // read_value[31:0], status[33:32], entry_count[42:34]
);
	import ilid_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);  // count width
	localparam int IW   = $clog2(CAPACITY);      // cell index width
	localparam int CMPW = (CW > 15) ? CW : 15;
	localparam int LVLS = tree_levels(CAPACITY);
	localparam int WW   = $clog2(LVLS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_PUT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   rd_idx_q;
	logic [WW-1:0]   wait_q;
	res_t            res_q;
	res_t            out_q;
	logic            out_valid_q;

	// request fields
	logic [2:0]      act;
	logic [15:0]     pos;
	logic [31:0]     val;
	logic            pos_neg;
	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic            in_range;
	logic            is_full;

	// decode results
	cell_op_t        dec_op;
	logic [IW-1:0]   dec_sel;
	logic [CW-1:0]   dec_cnt;
	logic            dec_read;
	res_t            dec_res;

	logic            accept;
	logic            out_free;
	logic            out_load;
	cell_cmd_t       cmd;
	logic [31:0]     tree_root;

	assign act = s_tdata[2:0];
	assign pos = s_tdata[18:3];
	assign val = s_tdata[50:19];

	assign pos_neg  = pos[15];
	assign pos_ext  = CMPW'(pos[14:0]);
	assign cnt_ext  = CMPW'(cnt_q);
	assign in_range = !pos_neg && (pos_ext < cnt_ext);
	assign is_full  = (cnt_q == CW'(CAPACITY));

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	// output register takes a result this cycle
	assign out_load = out_free && (((state_q == S_IDLE) && accept && !dec_read) ||
		((state_q == S_RD) && (wait_q == '0)) || (state_q == S_PUT));

	always_comb begin
		logic          ins_req;
		logic [IW-1:0] ins_at;
		ins_req  = 1'b0;
		ins_at   = '0;
		dec_op   = CELL_HOLD;
		dec_sel  = '0;
		dec_cnt  = cnt_q;
		dec_read = 1'b0;
		dec_res.read_value = '0;
		dec_res.status     = STAT_DONE;
		case (act)
			ACT_READ: begin
				if (in_range) begin
					dec_read = 1'b1;
				end else begin
					dec_res.read_value = RD_INVALID;
					dec_res.status     = STAT_BADPOS;
				end
			end
			ACT_INS_HEAD: begin
				ins_req = 1'b1;
			end
			ACT_INS_TAIL: begin
				ins_req = 1'b1;
				ins_at  = IW'(cnt_q);
			end
			ACT_INS_BEFORE: begin
				// position check comes ahead of the full check
				if (!pos_neg && (pos_ext > cnt_ext)) begin
					dec_res.status = STAT_BADPOS;
				end else begin
					ins_req = 1'b1;
					ins_at  = pos_neg ? '0 : IW'(pos_ext);
				end
			end
			ACT_DELETE: begin
				if (in_range) begin
					dec_op  = CELL_DEL;
					dec_sel = IW'(pos_ext);
					dec_cnt = cnt_q - CW'(1);
				end else begin
					dec_res.status = STAT_BADPOS;
				end
			end
			default: begin
				dec_res.status = STAT_BADPOS;
			end
		endcase
		if (ins_req) begin
			if (is_full) begin
				dec_res.status = STAT_FULL;
			end else begin
				dec_op  = CELL_INS;
				dec_sel = ins_at;
				dec_cnt = cnt_q + CW'(1);
			end
		end
		dec_res.entry_count = 9'(dec_cnt);
	end

	// cells move only on a taken request
	assign cmd.op   = accept ? dec_op : CELL_HOLD;
	assign cmd.data = val;

	// chain of cells
	logic [31:0] entry [CAPACITY];
	logic [31:0] hit   [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] from_left;
		logic [31:0] from_right;
		if (i == 0) begin : g_head
			assign from_left = val;
		end else begin : g_mid_l
			assign from_left = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign from_right = '0;
		end else begin : g_mid_r
			assign from_right = entry[i+1];
		end
		ilid_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.sel    (dec_sel),
			.rd_sel (rd_idx_q),
			.left   (from_left),
			.right  (from_right),
			.entry  (entry[i]),
			.hit    (hit[i])
		);
	end

	ilid_or_tree #(
		.LEAVES (CAPACITY)
	) u_tree (
		.clk  (clk),
		.leaf (hit),
		.root (tree_root)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= dec_cnt;
						if (dec_read) begin
							rd_idx_q <= IW'(pos_ext);
							wait_q   <= WW'(LVLS);
							state_q  <= S_RD;
						end else if (out_free) begin
							out_q       <= dec_res;
						end else begin
							res_q   <= dec_res;
							state_q <= S_PUT;
						end
					end
				end
				S_RD: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - WW'(1);
					end else if (out_free) begin
						out_q.read_value  <= tree_root;
						out_q.status      <= STAT_DONE;
						out_q.entry_count <= 9'(cnt_q);
						state_q           <= S_IDLE;
					end else begin
						res_q.read_value  <= tree_root;
						res_q.status      <= STAT_DONE;
						res_q.entry_count <= 9'(cnt_q);
						state_q           <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.entry_count, out_q.status, out_q.read_value};

endmodule
`default_nettype wire

>>> bench/tb_indexed_list_insert_delete_unit.sv
// Self-checking bench for the positional list store, streaming in and out.
`timescale 1ns / 100ps
module tb_indexed_list_insert_delete_unit;
	import ilid_pkg::*;

	localparam int LIST_CAP     = 256;
	localparam int ITEM_TARGET  = 1250;
	localparam int HOLD_AT      = 300;   // requests taken before the long receiver hold-off
	localparam int HOLD_CYCLES  = 100;
	localparam int STALL_LIMIT  = 3000;  // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	// actions 5..7 have no meaning in the block and must be refused
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BOTH} phase_t;

	// one entry of the driver's queue: either a request or a pause marker
	typedef struct packed {
		logic        pause;
		logic [55:0] data;
	} stim_t;

	localparam stim_t PAUSE_ITEM = '{pause: 1'b1, data: '0};

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;   // action[2:0], position[18:3], value[50:19], zero pad
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;   // read_value[31:0], status[33:32], entry_count[42:34]

	stim_t       request_q[$];
	logic [31:0] shadow_list[$];   // predicted contents, head first
	res_t        results_due[$];
	int          planned_count = 0;  // entry count as seen by the stimulus generator
	int          planned_items = 0;
	int          requests_taken = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	bit          hold_used = 1'b0;
	logic        req_taken;

	indexed_list_insert_delete_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: applies one request to the shadow list, returns the result
	// ------------------------------------------------------------------
	function automatic logic [1:0] shadow_insert(int at, logic [31:0] val);
		if (shadow_list.size() >= LIST_CAP)
			return STAT_FULL;
		shadow_list.insert(at, val);
		return STAT_DONE;
	endfunction

	function automatic res_t list_op_result(logic [55:0] req);
		logic [2:0]         act;
		logic signed [15:0] pos;
		logic [31:0]        val;
		int                 cnt;
		int                 p;
		res_t               r;
		act = req[2:0];
		pos = req[18:3];
		val = req[50:19];
		cnt = shadow_list.size();
		p = pos;
		r.read_value = '0;
		r.status = STAT_DONE;
		case (act)
			ACT_READ: begin
				if (p < 0 || p >= cnt) begin
					r.read_value = RD_INVALID;
					r.status = STAT_BADPOS;
				end else begin
					r.read_value = shadow_list[p];
				end
			end
			ACT_INS_HEAD: r.status = shadow_insert(0, val);
			ACT_INS_TAIL: r.status = shadow_insert(cnt, val);
			ACT_INS_BEFORE: begin
				// position beyond the tail is checked ahead of the full check
				if (p > cnt)
					r.status = STAT_BADPOS;
				else
					r.status = shadow_insert((p < 0) ? 0 : p, val);
			end
			ACT_DELETE: begin
				if (p < 0 || p >= cnt)
					r.status = STAT_BADPOS;
				else
					shadow_list.delete(p);
			end
			default: r.status = STAT_BADPOS;
		endcase
		r.entry_count = 9'(shadow_list.size());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------
	// queue one request; the generator tracks the count so that positions
	// can be aimed at the live range of the list
	task automatic add_req(logic [2:0] act, int pos, logic [31:0] val);
		logic signed [15:0] p;
		p = pos[15:0];
		request_q.push_back('{pause: 1'b0, data: {5'b0, val, p, act}});
		planned_items++;
		case (act)
			ACT_INS_HEAD, ACT_INS_TAIL:
				if (planned_count < LIST_CAP)
					planned_count++;
			ACT_INS_BEFORE:
				if (!(p > planned_count) && planned_count < LIST_CAP)
					planned_count++;
			ACT_DELETE:
				if (p >= 0 && p < planned_count)
					planned_count--;
			default: ;
		endcase
	endtask

	// a run of random requests leaning towards filling, draining or neither
	task automatic gen_phase(phase_t kind, int n);
		int          ins_pct;
		int          del_pct;
		int          r;
		int          pos;
		logic [2:0]  act;
		logic [31:0] val;
		case (kind)
			MIX_FILL:  begin ins_pct = 88; del_pct = 4;  end
			MIX_DRAIN: begin ins_pct = 6;  del_pct = 86; end
			default:   begin ins_pct = 45; del_pct = 30; end
		endcase
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: val = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				1: val = ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			if ($urandom_range(0, 99) < 3) begin
				// noise: an undefined action
				act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
				pos = $urandom;
			end else begin
				r = $urandom_range(0, 99);
				if (r < ins_pct) begin
					case ($urandom_range(0, 2))
						0: act = ACT_INS_HEAD;
						1: act = ACT_INS_TAIL;
						default: act = ACT_INS_BEFORE;
					endcase
				end else if (r < ins_pct + del_pct) begin
					act = ACT_DELETE;
				end else begin
					act = ACT_READ;
				end
				if ($urandom_range(0, 9) == 0) begin
					// off-range and edge positions
					case ($urandom_range(0, 4))
						0: pos = $urandom;
						1: pos = -1;
						2: pos = planned_count;
						3: pos = planned_count + 1;
						default: pos = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
					endcase
				end else if (act == ACT_INS_BEFORE) begin
					// once full, half of these sit beyond the tail: bad position wins
					if (kind == MIX_FILL && planned_count == LIST_CAP)
						pos = planned_count + int'($urandom_range(0, 1));
					else
						pos = $urandom_range(0, planned_count);
				end else if (act == ACT_INS_HEAD || act == ACT_INS_TAIL) begin
					pos = $urandom;   // ignored by the block
				end else begin
					pos = (planned_count > 0) ? int'($urandom_range(0, planned_count - 1)) : 0;
				end
			end
			add_req(act, pos, val);
		end
	endtask

	// long stretch with no idling on either side
	function automatic bit no_idle();
		return requests_taken >= 600 && requests_taken < 800;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: falling edge, holds each request until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_requests
		bit    go;
		stim_t nxt;
		if (arst_n) begin
			if (!s_tvalid || req_taken) begin
				// a pause marker releases only once every result is back
				if (request_q.size() != 0 && request_q[0].pause && results_due.size() == 0)
					void'(request_q.pop_front());
				go = request_q.size() != 0 && !request_q[0].pause &&
					(no_idle() || $urandom_range(0, 99) >= 34);
				if (go) begin
					nxt = request_q.pop_front();
					s_tdata <= nxt.data;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random back-pressure plus one long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_used && requests_taken >= HOLD_AT) begin
				// sender keeps offering, so the block fills and stalls its input
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle() || ($urandom_range(0, 99) >= 34);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: rising edge, predicts on request, checks on result
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sample
		res_t got;
		res_t want;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				results_due.push_back(list_op_result(s_tdata));
				requests_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[42:0]);
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with nothing due: %h", $realtime, m_tdata);
				end else begin
					want = results_due.pop_front();
					if (got.read_value !== want.read_value || got.status !== want.status ||
						got.entry_count !== want.entry_count) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: expected value %h status %0d count %0d, got value %h status %0d count %0d",
								$realtime, want.read_value, want.status, want.entry_count,
								got.read_value, got.status, got.entry_count);
					end
				end
			end
			// watchdog: only counts while work is outstanding
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(results_due.size() == 0 && request_q.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed requests, then fill / drain / mixed phases
	// ------------------------------------------------------------------
	initial begin : stimulus
		phase_t kind;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		req_taken = 1'b0;

		// empty list: read and delete both invalid
		add_req(ACT_READ, 0, 32'h0);
		add_req(ACT_DELETE, 0, 32'h0);
		// insert before on an empty list lands at the tail
		add_req(ACT_INS_BEFORE, 0, 32'h1111_1111);
		add_req(ACT_INS_HEAD, 32767, 32'h8000_0000);
		add_req(ACT_INS_TAIL, -32768, 32'h7FFF_FFFF);
		// negative position means head
		add_req(ACT_INS_BEFORE, -1, 32'h0000_0000);
		add_req(ACT_INS_BEFORE, -32768, 32'h0000_0001);
		// position equal to count means tail
		add_req(ACT_INS_BEFORE, 5, 32'hFFFF_FFFF);
		// beyond the tail: refused
		add_req(ACT_INS_BEFORE, 7, 32'hDEAD_BEEF);
		add_req(ACT_INS_BEFORE, 32767, 32'hDEAD_BEEF);
		add_req(ACT_INS_BEFORE, 2, 32'h1234_5678);
		add_req(ACT_READ, 0, 32'hFFFF_FFFF);
		add_req(ACT_READ, 6, 32'h0);
		add_req(ACT_READ, 3, 32'h0);
		// out-of-range reads
		add_req(ACT_READ, 7, 32'h0);
		add_req(ACT_READ, -1, 32'h0);
		add_req(ACT_READ, 32767, 32'h0);
		// out-of-range deletes
		add_req(ACT_DELETE, -1, 32'h0);
		add_req(ACT_DELETE, 7, 32'h0);
		add_req(ACT_DELETE, -32768, 32'h0);
		// undefined actions
		add_req(ACT_SPARE_FIRST, $urandom, $urandom);
		add_req(3'd6, $urandom, $urandom);
		add_req(ACT_SPARE_LAST, $urandom, $urandom);
		add_req(ACT_DELETE, 0, 32'h0);
		add_req(ACT_DELETE, 5, 32'h0);
		request_q.push_back(PAUSE_ITEM);

		// one full fill past capacity and one full drain, then random phases
		gen_phase(MIX_FILL, 330);
		request_q.push_back(PAUSE_ITEM);
		gen_phase(MIX_DRAIN, 330);
		request_q.push_back(PAUSE_ITEM);
		while (planned_items < ITEM_TARGET) begin
			kind = phase_t'($urandom_range(0, 2));
			gen_phase(kind, $urandom_range(60, 200));
			request_q.push_back(PAUSE_ITEM);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && results_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ilid_pkg.sv
rtl/core/ilid_cell.sv
rtl/core/ilid_or_tree.sv
rtl/core/indexed_list_insert_delete_unit.sv
bench/tb_indexed_list_insert_delete_unit.sv
